// ===== src/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants
// Term layout, opcodes and default table depth for the sparse polynomial
// adder core and its submodules.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int COEF_W        = 32;
  localparam int EXP_W         = 16;

  // Command opcodes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_EMIT = 2'd2;

  // One stored term
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic signed [EXP_W-1:0]  expo;
  } entry_t;

  // Compare flags from the shared unit
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

endpackage

// ===== src/spa_ram.sv =====
// ----------------------------------------------------------------------------
// spa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/spa_unit.sv =====
// ----------------------------------------------------------------------------
// spa_unit: shared compare and add unit
// Compares two term exponents (signed) and adds their coefficients with
// 32-bit wraparound. Used by both the add scan and the sort pass.
// ----------------------------------------------------------------------------
module spa_unit
  import spa_pkg::*;
(
  input  entry_t                   a,
  input  entry_t                   b,
  output cmp_t                     cmp,
  output logic signed [COEF_W-1:0] sum
);

  // Exponent compare
  assign cmp.eq = (a.expo == b.expo);
  assign cmp.gt = (a.expo > b.expo);

  // Coefficient add, wraps at the coefficient width
  assign sum = a.coef + b.coef;

endmodule

// ===== src/sparse_polynomial_adder_core.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_adder_core: sparse polynomial adder
// Command-driven term table with in-place exchange sort and ordered emit.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Load (opcode 0)
// appends one term unless the table is full. Add (opcode 1) scans the
// stored terms through the single RAM read port, one entry per cycle, and
// stores the term directly when the table is empty. Emit (opcode 2) runs the
// exchange sort over the same read port: for each position it loads the
// entry and then compares it against every later entry, one per cycle; each
// term is presented as soon as its position is final. Results appear for
// exactly one cycle under result_valid and cannot be held off, so the
// receiver must take every strobed result. An empty table gives one result
// with term_valid low and last_term high. Opcode 3 is ignored.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder_core
  import spa_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic signed [COEF_W-1:0] term_coefficient,
  input  logic signed [EXP_W-1:0]  term_exponent,
  output logic                     result_valid,
  output logic signed [COEF_W-1:0] sum_coefficient,
  output logic signed [EXP_W-1:0]  sum_exponent,
  output logic                     term_valid,
  output logic                     last_term,
  output logic                     terms_dropped
);

  localparam int IW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_LAST = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic          overflow;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic          matched;
  entry_t        cur;

  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;
  entry_t        rdata;

  entry_t                   in_term;
  cmp_t                     cmp;
  logic signed [COEF_W-1:0] sum;
  logic                     accept;
  logic                     full;
  logic                     j_last;
  logic                     i_last;
  logic                     pair;
  entry_t                   keep;
  entry_t                   other;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign in_term = '{coef: term_coefficient, expo: term_exponent};
  assign full    = (count == CW'(MAX_TERMS));
  assign j_last  = (CW'(j) == count - 1'b1);
  assign i_last  = (CW'(i) == count - 1'b1);
  assign pair    = (j == IW'(i + 1'b1));
  assign keep    = cmp.gt ? rdata : cur;
  assign other   = cmp.gt ? cur : rdata;

  // Term table
  spa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_TERMS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Shared compare and add against the held term
  spa_unit u_unit (
    .a  (cur),
    .b  (rdata),
    .cmp(cmp),
    .sum(sum)
  );

  // Drive table write and read ports
  always_comb begin
    we    = 1'b0;
    waddr = count[IW-1:0];
    wdata = in_term;
    raddr = IW'(j + 1'b1);
    unique case (state)
      ST_IDLE: begin
        raddr = '0;
        if (accept && !full && (opcode == OP_LOAD)) begin
          we = 1'b1;
        end else if (accept && (opcode == OP_ADD) && (count == '0)) begin
          we = 1'b1;
        end
      end
      ST_SCAN: begin
        if (cmp.eq) begin
          we    = 1'b1;
          waddr = j;
          wdata = '{coef: sum, expo: rdata.expo};
        end else if (j_last && !matched && !full) begin
          we    = 1'b1;
          wdata = cur;
        end
      end
      ST_LOAD: begin
        raddr = IW'(i + 1'b1);
      end
      ST_CMP: begin
        if (cmp.gt && !(j_last && pair)) begin
          we    = 1'b1;
          waddr = j;
          wdata = cur;
        end
        if (j_last) begin
          raddr = IW'(i + 1'b1);
        end
      end
      ST_LAST: begin
        raddr = '0;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      overflow     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            priority case (opcode)
              OP_LOAD: begin
                if (full) begin
                  overflow <= 1'b1;
                end else begin
                  count <= count + 1'b1;
                end
              end
              OP_ADD: begin
                if (count == '0) begin
                  count <= count + 1'b1;
                end else begin
                  cur     <= in_term;
                  j       <= '0;
                  matched <= 1'b0;
                  state   <= ST_SCAN;
                end
              end
              OP_EMIT: begin
                if (count == '0) begin
                  result_valid    <= 1'b1;
                  sum_coefficient <= '0;
                  sum_exponent    <= '0;
                  term_valid      <= 1'b0;
                  last_term       <= 1'b1;
                  terms_dropped   <= overflow;
                end else begin
                  i     <= '0;
                  state <= ST_LOAD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (cmp.eq) begin
            matched <= 1'b1;
          end
          if (j_last) begin
            if (!matched && !cmp.eq) begin
              if (full) begin
                overflow <= 1'b1;
              end else begin
                count <= count + 1'b1;
              end
            end
            state <= ST_IDLE;
          end else begin
            j <= IW'(j + 1'b1);
          end
        end
        ST_LOAD: begin
          if (i_last) begin
            result_valid    <= 1'b1;
            sum_coefficient <= rdata.coef;
            sum_exponent    <= rdata.expo;
            term_valid      <= 1'b1;
            last_term       <= 1'b1;
            terms_dropped   <= overflow;
            count           <= '0;
            state           <= ST_IDLE;
          end else begin
            cur   <= rdata;
            j     <= IW'(i + 1'b1);
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (j_last) begin
            // position i is final: present it
            result_valid    <= 1'b1;
            sum_coefficient <= keep.coef;
            sum_exponent    <= keep.expo;
            term_valid      <= 1'b1;
            last_term       <= 1'b0;
            terms_dropped   <= overflow;
            if (pair) begin
              // last two positions: hold the tail term instead of writing it
              cur   <= other;
              state <= ST_LAST;
            end else begin
              i     <= IW'(i + 1'b1);
              state <= ST_LOAD;
            end
          end else begin
            cur <= keep;
            j   <= IW'(j + 1'b1);
          end
        end
        ST_LAST: begin
          result_valid    <= 1'b1;
          sum_coefficient <= cur.coef;
          sum_exponent    <= cur.expo;
          term_valid      <= 1'b1;
          last_term       <= 1'b1;
          terms_dropped   <= overflow;
          count           <= '0;
          state           <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
